// ----- src/gradient_magnitude_and_angle_macros.svh -----
// Assertion macros for the gradient magnitude and angle block.
// The including module must provide the signals clock and reset.
`ifndef GRADIENT_MAGNITUDE_AND_ANGLE_MACROS_SVH
`define GRADIENT_MAGNITUDE_AND_ANGLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GMA_ASSERT_IMPLIES(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define GMA_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

// ----- src/gma_pkg.sv -----
// Shared types and constants of the gradient magnitude and angle block.
// No dependencies; used by the input stage, the CORDIC cells, the output stage and the top.
`default_nettype none

package gma_pkg;

   // Guard bits below the integer point of the x and y datapath.
   localparam int GUARD_BITS = 16;
   // Length of the arctangent table; the stage count may not exceed it.
   localparam int TABLE_LEN = 24;
   // Width of the Q30 angle accumulator (covers a bit more than +/- pi).
   localparam int ZW = 33;
   localparam int MAG_W = 16;
   localparam int ANGLE_W = 16;

   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 33'sd1686629713;
   localparam logic signed [ANGLE_W-1:0] ANGLE_PI_Q13 = 16'sd25736;
   localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_PI_Q13 = 16'sd12868;
   // Inverse CORDIC gain in the limit, Q32.
   localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;

   // atan(2^-i) truncated to Q30.
   localparam logic [29:0] ATAN_Q30 [TABLE_LEN] = '{
      30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
      30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
      30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
      30'd262143,    30'd131071,    30'd65535,     30'd32767,
      30'd16383,     30'd8191,      30'd4095,      30'd2047,
      30'd1023,      30'd511,       30'd255,       30'd127
   };

   // Result for vectors on an axis, decided at the input and carried alongside.
   typedef struct packed {
      logic                      special;
      logic [MAG_W-1:0]          magnitude;
      logic signed [ANGLE_W-1:0] angle;
   } side_type;

endpackage

`default_nettype wire

// ----- src/gma_prep.sv -----
// Input stage: axis special cases, scaling to guard bits and quadrant pre-rotation.
// Depends on gma_pkg.
`default_nettype none

module gma_prep #(
   parameter int GW = 16,
   parameter int XW = 35
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [GW-1:0]          grad_x,
   input  logic signed [GW-1:0]          grad_y,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [XW-1:0]          out_x,
   output logic signed [XW-1:0]          out_y,
   output logic signed [gma_pkg::ZW-1:0] out_z,
   output gma_pkg::side_type             out_side
);
   import gma_pkg::*;

   localparam int AW = GW + 1;
   localparam int SW = (AW > MAG_W) ? AW : MAG_W;

   logic                  valid_ff, valid_in;
   logic signed [XW-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]  z_ff, z_in;
   side_type              side_ff, side_in;

   logic signed [AW-1:0]  gx_ext, gy_ext;
   logic [AW-1:0]         abs_x, abs_y;
   logic signed [XW-1:0]  x_sh, y_sh;
   logic                  zero_x, zero_y;

   function automatic logic [MAG_W-1:0] sat_mag(input logic [AW-1:0] v);
      logic [SW-1:0] w;
      w = SW'(v);
      if (w > SW'(17'h0FFFF)) begin
         return 16'hFFFF;
      end
      return w[MAG_W-1:0];
   endfunction

   always_comb begin
      gx_ext = AW'(grad_x);
      gy_ext = AW'(grad_y);
      abs_x  = gx_ext[AW-1] ? AW'(-gx_ext) : AW'(gx_ext);
      abs_y  = gy_ext[AW-1] ? AW'(-gy_ext) : AW'(gy_ext);
      zero_x = (grad_x == '0);
      zero_y = (grad_y == '0);
      x_sh   = XW'(grad_x) <<< GUARD_BITS;
      y_sh   = XW'(grad_y) <<< GUARD_BITS;

      // Axis cases bypass the rotation entirely.
      side_in.special = zero_x | zero_y;
      if (zero_y) begin
         side_in.magnitude = sat_mag(abs_x);
         side_in.angle     = (grad_x[GW-1] == 1'b1) ? ANGLE_PI_Q13 : '0;
      end else begin
         side_in.magnitude = sat_mag(abs_y);
         side_in.angle     = grad_y[GW-1] ? -ANGLE_HALF_PI_Q13 : ANGLE_HALF_PI_Q13;
      end

      // Turn left half-plane vectors by a quarter turn so that x is not negative.
      if (!x_sh[XW-1]) begin
         x_in = x_sh;
         y_in = y_sh;
         z_in = '0;
      end else if (!y_sh[XW-1]) begin
         x_in = y_sh;
         y_in = -x_sh;
         z_in = HALF_PI_Q30;
      end else begin
         x_in = -y_sh;
         y_in = x_sh;
         z_in = -HALF_PI_Q30;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

// ----- src/gma_cell.sv -----
// One CORDIC vectoring micro-rotation with its own pipeline register.
// Depends on gma_pkg for the arctangent table and the side-band type.
`default_nettype none

module gma_cell #(
   parameter int XW = 35,
   parameter int STAGE = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [XW-1:0]          in_x,
   input  logic signed [XW-1:0]          in_y,
   input  logic signed [gma_pkg::ZW-1:0] in_z,
   input  gma_pkg::side_type             in_side,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [XW-1:0]          out_x,
   output logic signed [XW-1:0]          out_y,
   output logic signed [gma_pkg::ZW-1:0] out_z,
   output gma_pkg::side_type             out_side
);
   import gma_pkg::*;

   localparam logic signed [ZW-1:0] STEP_ANGLE = $signed(ZW'(ATAN_Q30[STAGE]));

   logic                 valid_ff, valid_in;
   logic signed [XW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   side_type             side_ff;
   logic signed [XW-1:0] x_sft, y_sft;
   logic                 y_neg;

   always_comb begin
      x_sft = in_x >>> STAGE;
      y_sft = in_y >>> STAGE;
      y_neg = in_y[XW-1];
      // Rotate toward the x axis; both updates use the incoming x and y.
      if (y_neg) begin
         x_in = in_x - y_sft;
         y_in = in_y + x_sft;
         z_in = in_z - STEP_ANGLE;
      end else begin
         x_in = in_x + y_sft;
         y_in = in_y - x_sft;
         z_in = in_z + STEP_ANGLE;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

// ----- src/gma_post.sv -----
// Output stages: gain correction multiply, angle rounding and clamping, result register.
// Depends on gma_pkg.
`default_nettype none

module gma_post #(
   parameter int XW = 35
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [XW-1:0]              in_x,
   input  logic signed [gma_pkg::ZW-1:0]     in_z,
   input  gma_pkg::side_type                 in_side,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [gma_pkg::MAG_W-1:0]         out_magnitude,
   output logic signed [gma_pkg::ANGLE_W-1:0] out_angle
);
   import gma_pkg::*;

   localparam int UW  = XW - 1;                 // non-negative x
   localparam int HW  = UW - GUARD_BITS;        // integer part of x
   localparam int TW  = HW + 33;                // partial product sum
   localparam int MFW = (HW + 1 > MAG_W) ? HW + 1 : MAG_W;

   // Multiply stage.
   logic                      a_valid_ff, a_valid_in, a_ready;
   logic [HW+31:0]            hi_ff, hi_in;
   logic [GUARD_BITS+31:0]    lo_ff, lo_in;
   logic signed [ANGLE_W-1:0] ang_ff, ang_in;
   side_type                  side_ff;
   logic [UW-1:0]             ux;
   logic signed [ZW-1:0]      z_rnd;
   logic signed [ANGLE_W-1:0] z_q13;

   // Result stage.
   logic                      b_valid_ff, b_valid_in, b_ready;
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic signed [ANGLE_W-1:0] angle_ff, angle_in;
   logic [TW-1:0]             t_sum, t_rnd;
   logic [MFW-1:0]            mag_full;
   logic [MAG_W-1:0]          mag_sat;

   always_comb begin
      ux    = in_x[XW-1] ? '0 : in_x[UW-1:0];
      hi_in = (HW+32)'(ux[UW-1:GUARD_BITS]) * (HW+32)'(INV_GAIN_Q32);
      lo_in = (GUARD_BITS+32)'(ux[GUARD_BITS-1:0]) * (GUARD_BITS+32)'(INV_GAIN_Q32);
      // Q30 to Q13, round half up, then clamp to +/- pi.
      z_rnd = (in_z + ZW'(65536)) >>> 17;
      z_q13 = z_rnd[ANGLE_W-1:0];
      if (in_side.special) begin
         ang_in = in_side.angle;
      end else if (z_q13 > ANGLE_PI_Q13) begin
         ang_in = ANGLE_PI_Q13;
      end else if (z_q13 < -ANGLE_PI_Q13) begin
         ang_in = -ANGLE_PI_Q13;
      end else begin
         ang_in = z_q13;
      end
   end

   assign in_ready   = !a_valid_ff || a_ready;
   assign a_valid_in = in_ready ? in_valid : a_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         hi_ff   <= hi_in;
         lo_ff   <= lo_in;
         ang_ff  <= ang_in;
         side_ff <= in_side;
      end
   end

   always_comb begin
      t_sum    = TW'(hi_ff) + TW'(lo_ff[GUARD_BITS+31:GUARD_BITS]);
      t_rnd    = t_sum + TW'(33'h0_8000_0000);
      mag_full = MFW'(t_rnd[TW-1:32]);
      mag_sat  = (mag_full > MFW'(17'h0FFFF)) ? 16'hFFFF : mag_full[MAG_W-1:0];
      mag_in   = side_ff.special ? side_ff.magnitude : mag_sat;
      angle_in = ang_ff;
   end

   assign a_ready    = !b_valid_ff || b_ready;
   assign b_ready    = out_ready;
   assign b_valid_in = a_ready ? a_valid_ff : b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && a_valid_ff) begin
         mag_ff   <= mag_in;
         angle_ff <= angle_in;
      end
   end

   assign out_valid     = b_valid_ff;
   assign out_magnitude = mag_ff;
   assign out_angle     = angle_ff;

endmodule

`default_nettype wire

// ----- src/gradient_magnitude_and_angle.sv -----
// Top level of the gradient magnitude and angle block.
// Depends on gma_pkg, gma_prep, gma_cell, gma_post and the assertion macro header.
`default_nettype none
`include "gradient_magnitude_and_angle_macros.svh"

// Gradient magnitude and angle. Each input transaction carries one pixel's
// horizontal and vertical gradient; each output transaction carries the
// rounded, gain-corrected length sqrt(x^2+y^2), saturated to 16 bits, and
// atan2(y, x) in radians with 13 fraction bits, clamped to -pi .. +pi.
// The zero vector gives magnitude 0 and angle 0, a vector on the negative
// x axis gives +pi. The block is a pipeline: one input stage that handles
// the axis cases and turns left half-plane vectors by a quarter turn, a
// chain of CORDIC_STAGES shift-add cells, each with its own shift and
// step angle, rotating the vector one step toward the x axis while adding
// up the angle, and two output stages (gain multiply and angle rounding,
// then the result register). A new transaction is taken in every clock
// cycle unless a stalled output has backed up the stages. Every stage
// holds its own valid bit, so gaps fill up while the output is stalled,
// and req_tready is formed combinationally from rsp_tready back through
// the stage chain. The block keeps no state between transactions.
module gradient_magnitude_and_angle #(
   parameter int CORDIC_STAGES  = 16,  // 8 .. 24
   parameter int GRADIENT_WIDTH = 16   // 8 .. 24
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // grad_x, then grad_y, each GRADIENT_WIDTH bits, padded to whole bytes
   input  logic [((2*GRADIENT_WIDTH+7)/8)*8-1:0]      req_tdata,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // [15:0] grad_magnitude, [31:16] grad_angle
   output logic [31:0]                                rsp_tdata
);
   import gma_pkg::*;

   // Guard bits plus headroom for the quarter turn and the CORDIC growth.
   localparam int XW = GRADIENT_WIDTH + GUARD_BITS + 3;

   logic signed [GRADIENT_WIDTH-1:0] grad_x, grad_y;

   logic                 chain_valid [0:CORDIC_STAGES];
   logic                 chain_ready [0:CORDIC_STAGES];
   logic signed [XW-1:0] chain_x     [0:CORDIC_STAGES];
   logic signed [XW-1:0] chain_y     [0:CORDIC_STAGES];
   logic signed [ZW-1:0] chain_z     [0:CORDIC_STAGES];
   side_type             chain_side  [0:CORDIC_STAGES];

   logic [MAG_W-1:0]          grad_magnitude;
   logic signed [ANGLE_W-1:0] grad_angle;

   assign grad_x = req_tdata[GRADIENT_WIDTH-1:0];
   assign grad_y = req_tdata[2*GRADIENT_WIDTH-1:GRADIENT_WIDTH];

   gma_prep #(
      .GW (GRADIENT_WIDTH),
      .XW (XW)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .grad_x    (grad_x),
      .grad_y    (grad_y),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_x     (chain_x[0]),
      .out_y     (chain_y[0]),
      .out_z     (chain_z[0]),
      .out_side  (chain_side[0])
   );

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      gma_cell #(
         .XW    (XW),
         .STAGE (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_x      (chain_x[i]),
         .in_y      (chain_y[i]),
         .in_z      (chain_z[i]),
         .in_side   (chain_side[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_x     (chain_x[i+1]),
         .out_y     (chain_y[i+1]),
         .out_z     (chain_z[i+1]),
         .out_side  (chain_side[i+1])
      );
   end

   gma_post #(
      .XW (XW)
   ) u_post (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (chain_valid[CORDIC_STAGES]),
      .in_ready      (chain_ready[CORDIC_STAGES]),
      .in_x          (chain_x[CORDIC_STAGES]),
      .in_z          (chain_z[CORDIC_STAGES]),
      .in_side       (chain_side[CORDIC_STAGES]),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_magnitude (grad_magnitude),
      .out_angle     (grad_angle)
   );

   assign rsp_tdata = {grad_angle, grad_magnitude};

   // The quarter turn at the input must leave x non-negative.
   `GMA_ASSERT_NEVER(a_prep_x_nonneg, chain_valid[0] && !chain_side[0].special && chain_x[0][XW-1], "input stage left x negative")
   // After the last rotation a nonzero vector lies near the positive x axis.
   `GMA_ASSERT_NEVER(a_final_x_pos, chain_valid[CORDIC_STAGES] && !chain_side[CORDIC_STAGES].special && chain_x[CORDIC_STAGES][XW-1], "rotated x is negative")
   // Delivered angles stay within +/- pi.
   `GMA_ASSERT_IMPLIES(a_angle_range, rsp_tvalid, (grad_angle <= ANGLE_PI_Q13) && (grad_angle >= -ANGLE_PI_Q13), "angle outside +/- pi")
   // With the result register empty every stage can move, so input is taken.
   `GMA_ASSERT_IMPLIES(a_ready_when_empty, !rsp_tvalid, req_tready, "pipeline stalled with empty output")

endmodule

`default_nettype wire

// ----- test/gradient_magnitude_and_angle_tb.sv -----
// Self-checking testbench for the gradient magnitude and angle block.
// Needs only the RTL top gradient_magnitude_and_angle and the files it pulls in.
`timescale 1ns / 100ps

module gradient_magnitude_and_angle_tb;

   // The block is built with its default sizes; the prediction below assumes them.
   localparam int STAGES        = 16;
   localparam int GRAD_W        = 16;
   localparam int GUARD_SHIFT   = 16;
   localparam int HALF_TURN_Q13 = 25736;
   localparam int QUARTER_TURN_Q13 = 12868;
   localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
   localparam longint unsigned GAIN_FIX_Q32 = 64'd2608131496;
   localparam int PRINT_CAP     = 40;

   // Rotation step angles, atan(2^-i), truncated to Q30.
   localparam longint STEP_ANGLE_Q30 [STAGES] = '{
      843314856, 497837829, 263043836, 133525158,
      67021686,  33543515,  16775850,  8388437,
      4194282,   2097149,   1048575,   524287,
      262143,    131071,    65535,     32767
   };

   // One result transaction, in the layout of rsp_tdata.
   typedef struct packed {
      logic signed [15:0] angle;
      logic [15:0]        magnitude;
   } polar_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [15:0] grad_x, [31:16] grad_y
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [15:0] grad_magnitude, [31:16] grad_angle
   logic [31:0] rsp_tdata;

   // Idle rates in percent; the main sequence changes them between phases.
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   // Set by the main sequence to start one long receiver hold-off.
   bit  start_hold = 1'b0;
   logic hold_rsp = 1'b0;

   always #5 clock = ~clock;

   gradient_magnitude_and_angle #(
      .CORDIC_STAGES (STAGES),
      .GRADIENT_WIDTH(GRAD_W)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // Computes the polar form of one gradient pixel the way the hardware does:
   // axis vectors are resolved directly, all others go through a quarter-turn
   // pre-rotation into the right half plane and then STAGES shift-add steps.
   function automatic polar_type predict_polar(logic signed [15:0] gx, logic signed [15:0] gy);
      polar_type           res;
      longint              x;
      longint              y;
      longint              z;
      longint              nx;
      longint              ny;
      longint              ang;
      longint unsigned     ux;
      longint unsigned     scaled;
      longint unsigned     mag;
      res = '0;
      if (gx == 0 && gy == 0) begin
         return res;
      end
      if (gy == 0) begin
         res.magnitude = (gx < 0) ? 16'(-longint'(gx)) : 16'(gx);
         res.angle = (gx > 0) ? 16'sd0 : 16'(HALF_TURN_Q13);
         return res;
      end
      if (gx == 0) begin
         res.magnitude = (gy < 0) ? 16'(-longint'(gy)) : 16'(gy);
         res.angle = (gy > 0) ? 16'(QUARTER_TURN_Q13) : 16'(-QUARTER_TURN_Q13);
         return res;
      end

      x = longint'(gx) * (64'sd1 <<< GUARD_SHIFT);
      y = longint'(gy) * (64'sd1 <<< GUARD_SHIFT);
      z = 0;
      // Left half plane: turn by a quarter so the vector has x >= 0.
      if (x < 0) begin
         if (y >= 0) begin
            nx = y;
            ny = -x;
            z  = QUARTER_TURN_Q30;
         end else begin
            nx = -y;
            ny = x;
            z  = -QUARTER_TURN_Q30;
         end
         x = nx;
         y = ny;
      end

      for (int i = 0; i < STAGES; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z  = z + STEP_ANGLE_Q30[i];
         end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z  = z - STEP_ANGLE_Q30[i];
         end
         x = nx;
         y = ny;
      end

      // Gain correction in two halves so the product stays within 64 bits.
      ux = (x < 0) ? 64'd0 : longint'(x);
      scaled = (ux >> 16) * GAIN_FIX_Q32 + (((ux & 64'hFFFF) * GAIN_FIX_Q32) >> 16);
      mag = (scaled + (64'd1 << 31)) >> 32;
      res.magnitude = (mag > 64'd65535) ? 16'hFFFF : 16'(mag);

      // Round the Q30 angle half up to Q13, then clamp to one half turn.
      ang = (z + (64'sd1 <<< 16)) >>> 17;
      if (ang > HALF_TURN_Q13) begin
         ang = HALF_TURN_Q13;
      end
      if (ang < -HALF_TURN_Q13) begin
         ang = -HALF_TURN_Q13;
      end
      res.angle = 16'(ang);
      return res;
   endfunction

   // Keeps the predicted results of accepted pixels in order and compares
   // every result transaction against the oldest of them.
   class polar_tracker;
      polar_type expected_polar_q[$];
      int        mismatch_count = 0;

      function void note_pixel(logic [31:0] data);
         expected_polar_q.push_back(predict_polar(data[15:0], data[31:16]));
      endfunction

      task report_polar_mismatch(string what, int got, int want);
         if (mismatch_count < PRINT_CAP) begin
            $display("%0t ns: mismatch in %s: got %0d, expected %0d", $realtime, what, got,
                     want);
         end
         mismatch_count++;
      endtask

      task check_polar(logic [31:0] data);
         polar_type got;
         polar_type want;
         got = data;
         if (expected_polar_q.size() == 0) begin
            report_polar_mismatch("unexpected result transaction", int'(data), 0);
         end else begin
            want = expected_polar_q.pop_front();
            if (got.magnitude !== want.magnitude) begin
               report_polar_mismatch("grad_magnitude", int'(got.magnitude),
                                     int'(want.magnitude));
            end
            if (got.angle !== want.angle) begin
               report_polar_mismatch("grad_angle", int'(got.angle), int'(want.angle));
            end
         end
      endtask

      function int pending();
         return expected_polar_q.size();
      endfunction
   endclass

   polar_tracker polar_sb = new();

   // Both monitors sample at the rising edge, before any of this edge's
   // nonblocking updates land, so they see the handshake as the block does.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         polar_sb.note_pixel(req_tdata);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         polar_sb.check_polar(rsp_tdata);
      end
   end

   // Receiver: one nonblocking update of rsp_tready per clock edge.
   always @(posedge clock) begin
      rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
   end

   // Long receiver hold-off, counted here so that the sender keeps offering
   // pixels and the pipeline fills up and pushes back on req_tready.
   initial begin
      wait (start_hold);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (300) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Offers one pixel, with random gaps before it, and returns at the edge
   // where the transaction is taken.
   task automatic send_pixel(logic [15:0] gx, logic [15:0] gy);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {gy, gx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Random pixel, weighted toward the axes, tiny vectors and the region
   // just around the negative x axis where the angle wraps.
   task automatic send_random_pixel();
      logic [15:0] gx;
      logic [15:0] gy;
      case ($urandom_range(9))
         0: begin
            gx = '0;
            gy = 16'($urandom);
         end
         1: begin
            gx = 16'($urandom);
            gy = '0;
         end
         2: begin
            gx = 16'($urandom_range(16)) - 16'd8;
            gy = 16'($urandom_range(16)) - 16'd8;
         end
         3: begin
            gx = {1'b1, 15'($urandom)};
            gy = 16'($urandom_range(8)) - 16'd4;
         end
         default: begin
            gx = 16'($urandom);
            gy = 16'($urandom);
         end
      endcase
      send_pixel(gx, gy);
   endtask

   // Drops valid and waits until every predicted result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (polar_sb.pending() != 0) @(posedge clock);
   endtask

   // Directed pixels: zero vector, both axes in both directions, field
   // extremes, all four diagonals and the vectors next to the negative x
   // axis, where the rounded angle can run past a half turn and is clamped.
   logic [15:0] directed_x [] = '{
      16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF,
      16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0001,
      16'hFFFF, 16'hFFFF, 16'h0001, 16'h8000, 16'h8000, 16'hFFFF, 16'h3039,
      16'hFFFF, 16'h5555, 16'hAAAA
   };
   logic [15:0] directed_y [] = '{
      16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000,
      16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001,
      16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h8000, 16'hE57B,
      16'h7FFF, 16'hAAAA, 16'h5555
   };

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase one: slow receiver, sender mostly busy.
      send_idle_pct = 26;
      recv_idle_pct = 75;
      foreach (directed_x[i]) begin
         send_pixel(directed_x[i], directed_y[i]);
      end
      repeat (230) send_random_pixel();
      drain_results();

      // Phase two: the other way round.
      send_idle_pct = 75;
      recv_idle_pct = 26;
      repeat (250) send_random_pixel();
      drain_results();

      // Phase three: full rate on both sides, with one long hold-off.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      start_hold = 1'b1;
      repeat (270) send_random_pixel();
      drain_results();

      // The pipeline is 19 stages deep; give any stray result time to show.
      repeat (40) @(posedge clock);
      if (polar_sb.mismatch_count == 0 && polar_sb.pending() == 0) begin
         $display("PASS gradient_magnitude_and_angle");
      end else begin
         $display("FAIL gradient_magnitude_and_angle");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("FAIL gradient_magnitude_and_angle");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/gma_pkg.sv
src/gma_prep.sv
src/gma_cell.sv
src/gma_post.sv
src/gradient_magnitude_and_angle.sv
test/gradient_magnitude_and_angle_tb.sv
